/* hw/rtl/fcgl_pkg.sv */
// ----------------------------------------------------------------------------
// fcgl_pkg
// Shared types and constants of the codepoint to glyph index lookup block.
// ----------------------------------------------------------------------------
package fcgl_pkg;

   localparam int MAX_MAPS    = 16;
   localparam int LIST_DEPTH  = 1024;

   localparam int MAP_IDX_W   = (MAX_MAPS > 1) ? $clog2(MAX_MAPS) : 1;
   localparam int MAP_CNT_W   = $clog2(MAX_MAPS + 1);
   localparam int LIST_ADDR_W = $clog2(LIST_DEPTH);
   localparam int LIST_CNT_W  = $clog2(LIST_DEPTH + 1);

   localparam int MAP_COUNT_W = 5;
   localparam int KIND_W      = 2;
   localparam int SLOT_W      = 10;
   localparam int CP_W        = 21;
   localparam int MTYPE_W     = 2;
   localparam int GLYPH_W     = 16;
   localparam int OFFSET_W    = 10;
   localparam int COUNT_W     = 11;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_MAP_WR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LIST_WR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd2;

   // map types
   localparam logic [MTYPE_W-1:0] MTYPE_SEQ    = 2'd0;
   localparam logic [MTYPE_W-1:0] MTYPE_SPARSE = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_RD,
      ST_MAP_CHK,
      ST_SRCH,
      ST_PROBE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SLOT_W-1:0]   slot;
      logic [CP_W-1:0]     codepoint;
      logic [CP_W-1:0]     range_span;
      logic [MTYPE_W-1:0]  map_type;
      logic [GLYPH_W-1:0]  glyph_base;
      logic [OFFSET_W-1:0] list_offset;
      logic [COUNT_W-1:0]  list_count;
   } req_item_type;

   typedef struct packed {
      logic [CP_W-1:0]     start;
      logic [CP_W-1:0]     length;
      logic [MTYPE_W-1:0]  mtype;
      logic [GLYPH_W-1:0]  base;
      logic [OFFSET_W-1:0] offset;
      logic [COUNT_W-1:0]  count;
   } map_entry_type;

   typedef struct packed {
      logic                found;
      logic [GLYPH_W-1:0]  glyph;
   } result_type;

endpackage

/* hw/rtl/fcgl_core.sv */
// ----------------------------------------------------------------------------
// fcgl_core
// Map table and sparse list memories with the sequencer that walks the maps
// and binary-searches sparse list slices.
// ----------------------------------------------------------------------------
module fcgl_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_fire,
   input  fcgl_pkg::req_item_type              req_item,
   input  logic [fcgl_pkg::MAP_COUNT_W-1:0]    map_count,
   output logic                                idle,
   output logic                                res_valid,
   input  logic                                res_ready,
   output fcgl_pkg::result_type                res
);
   import fcgl_pkg::*;

   state_type                 state_ff, state_in;
   logic [CP_W-1:0]           cp_ff, cp_in;
   logic [MAP_CNT_W-1:0]      n_ff, n_in;
   logic [MAP_IDX_W-1:0]      m_ff, m_in;
   logic [LIST_CNT_W-1:0]     lo_ff, lo_in;
   logic [LIST_CNT_W-1:0]     hi_ff, hi_in;
   logic [LIST_CNT_W-1:0]     mid_ff, mid_in;
   logic [GLYPH_W-1:0]        base_ff, base_in;
   logic [OFFSET_W-1:0]       offset_ff, offset_in;
   logic                      found_ff, found_in;
   logic [GLYPH_W-1:0]        glyph_ff, glyph_in;

   map_entry_type             map_mem [MAX_MAPS];
   map_entry_type             map_q;
   logic [CP_W-1:0]           list_mem [LIST_DEPTH];
   logic [CP_W-1:0]           list_q;
   logic [LIST_ADDR_W-1:0]    list_rd_addr;

   map_entry_type             wr_entry;
   logic                      map_wr;
   logic                      list_wr;

   always_comb begin
      wr_entry.start  = req_item.codepoint;
      wr_entry.length = req_item.range_span;
      wr_entry.mtype  = req_item.map_type;
      wr_entry.base   = req_item.glyph_base;
      wr_entry.offset = req_item.list_offset;
      wr_entry.count  = req_item.list_count;
      map_wr  = req_fire && (req_item.kind == KIND_MAP_WR)
                && (32'(req_item.slot) < MAX_MAPS);
      list_wr = req_fire && (req_item.kind == KIND_LIST_WR)
                && (32'(req_item.slot) < LIST_DEPTH);
   end

   // map table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (map_wr) begin
         map_mem[MAP_IDX_W'(req_item.slot)] <= wr_entry;
      end
      map_q <= map_mem[m_ff];
   end

   // sparse codepoint list
   always_ff @(posedge clock) begin
      if (list_wr) begin
         list_mem[LIST_ADDR_W'(req_item.slot)] <= req_item.codepoint;
      end
      list_q <= list_mem[list_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_ff     <= cp_in;
      n_ff      <= n_in;
      m_ff      <= m_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      base_ff   <= base_in;
      offset_ff <= offset_in;
      found_ff  <= found_in;
      glyph_ff  <= glyph_in;
   end

   always_comb begin
      logic [CP_W-1:0]       rel;
      logic                  in_range;
      logic                  last_map;
      logic [LIST_CNT_W-1:0] mid_c;
      logic [31:0]           addr_sum;

      state_in     = state_ff;
      cp_in        = cp_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      base_in      = base_ff;
      offset_in    = offset_ff;
      found_in     = found_ff;
      glyph_in     = glyph_ff;

      rel      = cp_ff - map_q.start;
      in_range = (cp_ff >= map_q.start) && (rel < map_q.length);
      last_map = ((MAP_CNT_W'(m_ff) + MAP_CNT_W'(1)) == n_ff);
      mid_c    = lo_ff + ((hi_ff - lo_ff) >> 1);
      addr_sum = 32'(offset_ff) + 32'(mid_c);
      if (addr_sum >= LIST_DEPTH) begin
         addr_sum = addr_sum - LIST_DEPTH;
      end
      list_rd_addr = LIST_ADDR_W'(addr_sum);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_item.kind == KIND_LOOKUP)) begin
               cp_in = req_item.codepoint;
               m_in  = '0;
               if (32'(map_count) > MAX_MAPS) begin
                  n_in = MAP_CNT_W'(MAX_MAPS);
               end else begin
                  n_in = MAP_CNT_W'(map_count);
               end
               if (map_count == '0) begin
                  found_in = 1'b0;
                  glyph_in = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MAP_RD;
               end
            end
         end
         ST_MAP_RD: begin
            state_in = ST_MAP_CHK;
         end
         ST_MAP_CHK: begin
            if (in_range && (map_q.mtype == MTYPE_SEQ)) begin
               found_in = 1'b1;
               glyph_in = map_q.base + GLYPH_W'(rel);
               state_in = ST_DONE;
            end else if (in_range && (map_q.mtype == MTYPE_SPARSE)) begin
               base_in   = map_q.base;
               offset_in = map_q.offset;
               lo_in     = '0;
               if (32'(map_q.count) > LIST_DEPTH) begin
                  hi_in = LIST_CNT_W'(LIST_DEPTH);
               end else begin
                  hi_in = LIST_CNT_W'(map_q.count);
               end
               state_in = ST_SRCH;
            end else if (last_map) begin
               found_in = 1'b0;
               glyph_in = '0;
               state_in = ST_DONE;
            end else begin
               m_in     = m_ff + MAP_IDX_W'(1);
               state_in = ST_MAP_RD;
            end
         end
         ST_SRCH: begin
            // list read of the probe word is issued here
            if (lo_ff < hi_ff) begin
               mid_in   = mid_c;
               state_in = ST_PROBE;
            end else if (last_map) begin
               found_in = 1'b0;
               glyph_in = '0;
               state_in = ST_DONE;
            end else begin
               m_in     = m_ff + MAP_IDX_W'(1);
               state_in = ST_MAP_RD;
            end
         end
         ST_PROBE: begin
            if (list_q == cp_ff) begin
               found_in = 1'b1;
               glyph_in = base_ff + GLYPH_W'(mid_ff);
               state_in = ST_DONE;
            end else begin
               if (list_q < cp_ff) begin
                  lo_in = mid_ff + LIST_CNT_W'(1);
               end else begin
                  hi_in = mid_ff;
               end
               state_in = ST_SRCH;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res.found = found_ff;
   assign res.glyph = glyph_ff;

endmodule

/* hw/rtl/font_codepoint_glyph_lookup_top.sv */
// ----------------------------------------------------------------------------
// font_codepoint_glyph_lookup_top
// Codepoint to glyph index lookup through a table of character maps.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer; req_tuser is the kind. A map entry
//   write or a list word write lands in its memory in the transfer cycle and
//   gives no result, so loads stream at one per cycle while the core is
//   idle. A lookup walks the maps in order and sends one rsp_* transfer:
//   rsp_tuser is found, rsp_tdata the glyph index (zero when not found).
//   csr_* writes map_count; write it only while no lookup is in flight.
// A lookup reads the map table and list memory through registered read ports:
//   each map visited is read and checked, and a matching sparse map is
//   binary-searched, each probe reading and comparing one list word; at
//   most 16 maps are visited with up to 11 probes each.
//   req_tready stays low until the result leaves the core.
// Reset closes req and csr, clears the sequencer state, the output valid flag
//   and map_count; the map table and list memory hold garbage until written.
// A stalled receiver holds the result in the output register; the next
//   item is still taken and worked on, and its result waits for the slot.
// ----------------------------------------------------------------------------
module font_codepoint_glyph_lookup_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // slot[9:0] codepoint[30:10] range_span[51:31] map_type[53:52]
   // glyph_base[69:54] list_offset[79:70] list_count[90:80], zero above
   input  logic [95:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // glyph_index[15:0]
   output logic [15:0] rsp_tdata,
   // found[0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   import fcgl_pkg::*;

   req_item_type            req_item;
   logic                    req_fire;
   logic                    core_idle;
   logic                    res_valid;
   logic                    res_ready;
   result_type              res;

   logic [MAP_COUNT_W-1:0]  map_count_ff, map_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, rsp_in;

   always_comb begin
      req_item.kind         = req_tuser;
      req_item.slot         = req_tdata[9:0];
      req_item.codepoint    = req_tdata[30:10];
      req_item.range_span   = req_tdata[51:31];
      req_item.map_type     = req_tdata[53:52];
      req_item.glyph_base   = req_tdata[69:54];
      req_item.list_offset  = req_tdata[79:70];
      req_item.list_count   = req_tdata[90:80];
   end

   assign req_tready = core_idle && !reset;
   assign req_fire   = req_tvalid && req_tready;

   fcgl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_item  (req_item),
      .map_count (map_count_ff),
      .idle      (core_idle),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;
   assign csr_ready = !reset;

   always_comb begin
      map_count_in = map_count_ff;
      if (csr_valid && csr_ready) begin
         map_count_in = csr_data;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         // drop the slot once the receiver takes the transfer
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_count_ff <= map_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_ff.glyph;
   assign rsp_tuser[0] = rsp_ff.found;

   // a lookup keeps the input closed for at least the next cycle
   a_lookup_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == KIND_LOOKUP)) |=> !req_tready)
      else $error("input open right after a lookup transfer");

   // the output slot only fills from a finished lookup
   a_rsp_from_core: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid)) |-> $past(res_valid))
      else $error("result appeared without a finished lookup");

   // a miss carries glyph index zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("miss with nonzero glyph index");

   // a finished result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("waiting result lost");

endmodule
